FILE: rtl/core/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// shared codes, field widths and record types of the matrix multiply engine
// ----------------------------------------------------------------------------
package mme_pkg;

    // stream widths
    localparam int S_TDATA_W = 40;   // row_index, col_index, elem_value
    localparam int S_TUSER_W = 2;    // opcode
    localparam int M_TDATA_W = 40;   // out_col, product_value, zero pad
    localparam int M_TUSER_W = 1;    // status

    // configuration port
    localparam int PADDR_W = 4;

    // opcodes
    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    // status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    // one result item
    typedef struct packed {
        logic        status;
        logic [3:0]  col;
        logic [31:0] value;
        logic        last;
    } res_t;

    // tags that travel with one multiply-accumulate term
    typedef struct packed {
        logic [3:0] col;
        logic       first;     // first term of a dot product
        logic       last_term; // final term of a dot product
        logic       last_col;  // dot product of the final column
    } tag_t;

endpackage

FILE: rtl/core/matrix_multiply_engine_unit.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine_unit
// integer matrix product C = A x B over two on-chip element stores
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// s_       in   s_tvalid / s_tready    s_tdata: row, col, value; s_tuser: opcode
// m_       out  m_tvalid / m_tready    m_tdata: col, value; m_tuser: status; m_tlast
// apb      in   psel / penable / pready  rows_a, inner_dim, cols_b at 0x0, 0x4, 0x8
//
// a write request answers with one status result.
// a row request issues one multiply-accumulate per cycle unless the full result
// queue holds the pipeline, cols_b * inner_dim terms in all; the next request is
// taken once the last term has left the pipeline.
// after reset a clearing pass zeroes all MAX_DIM * MAX_DIM entries of both
// stores; no request is taken during it.
// a two-entry result queue parts the sides; when it is full and not drained
// the whole multiply pipeline holds.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_unit #(
    parameter int MAX_DIM    = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mme_pkg::S_TDATA_W-1:0] s_tdata,  // [3:0] row_index, [7:4] col_index,
                                                    // [39:8] elem_value
    input  logic [mme_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] opcode
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mme_pkg::M_TDATA_W-1:0] m_tdata,  // [3:0] out_col, [35:4] product_value,
                                                    // [39:36] zero
    output logic [mme_pkg::M_TUSER_W-1:0] m_tuser,  // [0] status
    output logic                          m_tlast,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mme_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import mme_pkg::*;

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OPW     = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int CAP_INT = (MAX_DIM < 16) ? MAX_DIM : 16;
    localparam logic [4:0]    DIM_CAP   = 5'(CAP_INT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam logic [1:0] SEQ_IDLE  = 2'd0;
    localparam logic [1:0] SEQ_CLEAR = 2'd1;
    localparam logic [1:0] SEQ_RUN   = 2'd2;

    // saturate a register value into 1..cap
    function automatic logic [4:0] dim_clamp(input logic [4:0] v);
        logic [4:0] x;
        x = v;
        if (x == 5'd0)
            x = 5'd1;
        if (x > DIM_CAP)
            x = DIM_CAP;
        return x;
    endfunction

    // row-major store address
    function automatic logic [AW-1:0] addr_of(input logic [3:0] r, input logic [3:0] c);
        logic [31:0] t;
        t = 32'(r) * 32'(MAX_DIM) + 32'(c);
        return t[AW-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [4:0] rows_reg, inner_reg, cols_reg;
    logic       cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= DIM_CAP;
            inner_reg <= DIM_CAP;
            cols_reg  <= DIM_CAP;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_ROWS_A:    rows_reg  <= dim_clamp(pwdata[4:0]);
                REG_INNER_DIM: inner_reg <= dim_clamp(pwdata[4:0]);
                REG_COLS_B:    cols_reg  <= dim_clamp(pwdata[4:0]);
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[3:2])
            REG_ROWS_A:    prdata = {27'd0, rows_reg};
            REG_INNER_DIM: prdata = {27'd0, inner_reg};
            REG_COLS_B:    prdata = {27'd0, cols_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------------
    logic [1:0]            op_in;
    logic [3:0]            row_in, col_in;
    logic signed [31:0]    elem_in;
    logic [DATA_WIDTH-1:0] elem_w;
    logic                  accept;
    logic                  a_ok, b_ok, c_ok;
    logic                  wr_a, wr_b, start_run;
    res_t                  acc_res;
    logic                  acc_push;

    assign op_in   = s_tuser[1:0];
    assign row_in  = s_tdata[3:0];
    assign col_in  = s_tdata[7:4];
    assign elem_in = s_tdata[39:8];
    assign elem_w  = DATA_WIDTH'(elem_in);
    assign accept  = s_tvalid && s_tready;

    assign a_ok = ({1'b0, row_in} < rows_reg)  && ({1'b0, col_in} < inner_reg);
    assign b_ok = ({1'b0, row_in} < inner_reg) && ({1'b0, col_in} < cols_reg);
    assign c_ok = ({1'b0, row_in} < rows_reg);

    // write acknowledgement or single error answer
    always_comb begin
        acc_res.status = STATUS_ERR;
        acc_res.col    = 4'd0;
        acc_res.value  = 32'd0;
        acc_res.last   = 1'b1;
        wr_a      = 1'b0;
        wr_b      = 1'b0;
        start_run = 1'b0;
        case (op_in)
            OP_WRITE_A: begin
                if (a_ok) begin
                    wr_a           = 1'b1;
                    acc_res.status = STATUS_OK;
                end
            end
            OP_WRITE_B: begin
                if (b_ok) begin
                    wr_b           = 1'b1;
                    acc_res.status = STATUS_OK;
                end
            end
            OP_COMPUTE: start_run = c_ok;
            default: ;
        endcase
    end

    assign acc_push = accept && !start_run;

    // ------------------------------------------------------------------------
    // sequencer: clearing pass and term issue
    // ------------------------------------------------------------------------
    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [3:0]    row_reg, row_next;
    logic [3:0]    j_reg, j_next;
    logic [3:0]    k_reg, k_next;
    logic          en;
    logic          issue;
    tag_t          issue_tag;

    assign issue               = (state_reg == SEQ_RUN) && en;
    assign issue_tag.col       = j_reg;
    assign issue_tag.first     = (k_reg == 4'd0);
    assign issue_tag.last_term = ({1'b0, k_reg} == (inner_reg - 5'd1));
    assign issue_tag.last_col  = ({1'b0, j_reg} == (cols_reg - 5'd1));

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        row_next   = row_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            SEQ_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                    state_next = SEQ_IDLE;
            end
            SEQ_IDLE: begin
                if (accept && start_run) begin
                    state_next = SEQ_RUN;
                    row_next   = row_in;
                    j_next     = 4'd0;
                    k_next     = 4'd0;
                end
            end
            SEQ_RUN: begin
                if (en) begin
                    if (issue_tag.last_term) begin
                        k_next = 4'd0;
                        if (issue_tag.last_col)
                            state_next = SEQ_IDLE;
                        else
                            j_next = j_reg + 4'd1;
                    end else begin
                        k_next = k_reg + 4'd1;
                    end
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_CLEAR;
            clr_reg   <= '0;
            j_reg     <= 4'd0;
            k_reg     <= 4'd0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg <= row_next;
    end

    // ------------------------------------------------------------------------
    // element stores
    // ------------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] a_mem [DEPTH];
    logic [DATA_WIDTH-1:0] b_mem [DEPTH];
    logic                  a_we, b_we;
    logic [AW-1:0]         wr_addr, a_raddr, b_raddr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] a_rdata_reg, b_rdata_reg;
    logic                  clearing;

    assign clearing = (state_reg == SEQ_CLEAR);
    assign a_we     = clearing || (accept && wr_a);
    assign b_we     = clearing || (accept && wr_b);
    assign wr_addr  = clearing ? clr_reg : addr_of(row_in, col_in);
    assign wr_data  = clearing ? '0 : elem_w;
    assign a_raddr  = addr_of(row_reg, k_reg);
    assign b_raddr  = addr_of(k_reg, j_reg);

    always_ff @(posedge aclk) begin
        if (a_we)
            a_mem[wr_addr] <= wr_data;
        if (en)
            a_rdata_reg <= a_mem[a_raddr];
    end

    always_ff @(posedge aclk) begin
        if (b_we)
            b_mem[wr_addr] <= wr_data;
        if (en)
            b_rdata_reg <= b_mem[b_raddr];
    end

    // ------------------------------------------------------------------------
    // multiply-accumulate pipeline
    // ------------------------------------------------------------------------
    logic                    s1_valid_reg, s2_valid_reg;
    tag_t                    s1_tag_reg, s2_tag_reg;
    logic signed [OPW-1:0]   a_op, b_op;
    logic signed [2*OPW-1:0] prod_full;
    logic [2*OPW-1:0]        prod_reg;
    logic [DATA_WIDTH-1:0]   acc_reg, acc_base, acc_next;
    logic signed [DATA_WIDTH-1:0] acc_s;
    logic                    run_push;
    res_t                    run_res;

    assign a_op      = a_rdata_reg[OPW-1:0];
    assign b_op      = b_rdata_reg[OPW-1:0];
    assign prod_full = a_op * b_op;
    assign acc_base  = s2_tag_reg.first ? '0 : acc_reg;
    assign acc_next  = acc_base + prod_reg[DATA_WIDTH-1:0];
    assign acc_s     = acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_tag_reg <= issue_tag;
            s2_tag_reg <= s1_tag_reg;
            prod_reg   <= prod_full;
            if (s2_valid_reg)
                acc_reg <= acc_next;
        end
    end

    // finished dot product
    assign run_push       = en && s2_valid_reg && s2_tag_reg.last_term;
    assign run_res.status = STATUS_OK;
    assign run_res.col    = s2_tag_reg.col;
    assign run_res.value  = 32'(acc_s);
    assign run_res.last   = s2_tag_reg.last_col;

    // ------------------------------------------------------------------------
    // result queue, two entries
    // ------------------------------------------------------------------------
    res_t       fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    res_t       push_res, head;

    assign push     = run_push || acc_push;
    assign push_res = run_push ? run_res : acc_res;
    assign pop      = m_tvalid && m_tready;
    assign en       = (cnt_reg != 2'd2) || pop;

    assign s_tready = (state_reg == SEQ_IDLE) && !s1_valid_reg && !s2_valid_reg && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            fifo_reg[wr_ptr_reg] <= push_res;
    end

    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {4'd0, head.value, head.col};
    assign m_tuser  = head.status;
    assign m_tlast  = head.last;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_queue_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> (cnt_reg != 2'd2))
        else $error("result queue written while full");

    a_pipe_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en && s2_valid_reg) |=> (s2_valid_reg && $stable(prod_reg)))
        else $error("multiply stage moved while the queue was blocked");

    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_push && s2_tag_reg.last_col) |-> (state_reg == SEQ_IDLE))
        else $error("final column drained while terms still being issued");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the matrix multiply engine against a cycle-free model of its stores
// ----------------------------------------------------------------------------
// element writes, row computes and malformed requests are pushed into the
// request stream. A model of both stores works out every answer, and each
// accepted result is compared against the oldest pending answer. Dimensions
// change between phases over the APB port. Sender gaps and receiver stalls
// vary from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import mme_pkg::*;

    localparam int          MAX_DIM      = 16;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          SETTLE_CYCLES = 4;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    // model of the two element stores and the product rows they give
    class product_scoreboard;
        logic [31:0] a_elems [MAX_DIM][MAX_DIM];
        logic [31:0] b_elems [MAX_DIM][MAX_DIM];
        int unsigned rows_a;
        int unsigned inner_dim;
        int unsigned cols_b;
        res_t        pending[$];
        int unsigned fail_count;
        int unsigned request_count;
        int unsigned result_count;
        int unsigned rows_computed;
        int unsigned error_answers;

        function new();
            for (int i = 0; i < MAX_DIM; i++) begin
                for (int j = 0; j < MAX_DIM; j++) begin
                    a_elems[i][j] = '0;
                    b_elems[i][j] = '0;
                end
            end
            rows_a = MAX_DIM;
            inner_dim = MAX_DIM;
            cols_b = MAX_DIM;
            fail_count = 0;
            request_count = 0;
            result_count = 0;
            rows_computed = 0;
            error_answers = 0;
        endfunction

        // register write: low five bits, saturated into 1..MAX_DIM
        function void set_dimension(logic [1:0] index, logic [31:0] value);
            int unsigned dim;
            dim = value[4:0];
            if (dim < 1)
                dim = 1;
            if (dim > MAX_DIM)
                dim = MAX_DIM;
            case (index)
                REG_ROWS_A:    rows_a = dim;
                REG_INNER_DIM: inner_dim = dim;
                REG_COLS_B:    cols_b = dim;
                default: ;
            endcase
        endfunction

        // accepted request: update the stores and queue its answers
        function void note_request(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                                   logic [31:0] value);
            res_t        answer;
            logic [31:0] acc;
            bit          is_row;
            request_count++;
            is_row = 1'b0;
            answer.status = STATUS_ERR;
            answer.col = '0;
            answer.value = '0;
            answer.last = 1'b1;
            case (op)
                OP_WRITE_A: begin
                    if (row < rows_a && col < inner_dim) begin
                        a_elems[row][col] = value;
                        answer.status = STATUS_OK;
                    end
                end
                OP_WRITE_B: begin
                    if (row < inner_dim && col < cols_b) begin
                        b_elems[row][col] = value;
                        answer.status = STATUS_OK;
                    end
                end
                OP_COMPUTE: begin
                    is_row = (row < rows_a);
                end
                default: ;
            endcase
            if (is_row) begin
                rows_computed++;
                for (int j = 0; j < cols_b; j++) begin
                    acc = '0;
                    for (int k = 0; k < inner_dim; k++)
                        acc += a_elems[row][k] * b_elems[k][j];
                    answer.status = STATUS_OK;
                    answer.col = 4'(j);
                    answer.value = acc;
                    answer.last = (j + 1 == cols_b);
                    pending.push_back(answer);
                end
            end else begin
                if (answer.status == STATUS_ERR)
                    error_answers++;
                pending.push_back(answer);
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                fail_count++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        // accepted result: compare with the oldest pending answer
        function void check_result(res_t got);
            res_t want;
            result_count++;
            if (pending.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, actual %0h",
                         $time, got);
            end else begin
                want = pending.pop_front();
                compare_field("status", 32'(want.status), 32'(got.status));
                compare_field("out_col", 32'(want.col), 32'(got.col));
                compare_field("product_value", want.value, got.value);
                compare_field("last", 32'(want.last), 32'(got.last));
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    product_scoreboard    sb;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int unsigned          cycle_count;
    int unsigned          dim_settings;

    matrix_multiply_engine_unit #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (32)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run limit reached with %0d results pending",
                     $time, sb.pending.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    // result side: check accepted results, then pick the next ready level
    always @(posedge aclk) begin
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser[0];
            got.col = m_tdata[3:0];
            got.value = m_tdata[35:4];
            got.last = m_tlast;
            sb.check_result(got);
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one request, held until the block takes it
    task automatic send_request(input logic [1:0] op, input logic [3:0] row,
                                input logic [3:0] col, input logic [31:0] value);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {value, col, row};
        s_tuser <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_request(op, row, col, value);
    endtask

    // stop sending and wait for every pending answer
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // back-to-back APB writes of all three dimension registers
    task automatic write_dimensions(input int rows, input int inner, input int cols);
        logic [1:0] reg_list [3];
        int         values [3];
        reg_list = '{REG_ROWS_A, REG_INNER_DIM, REG_COLS_B};
        values = '{rows, inner, cols};
        for (int i = 0; i < 3; i++) begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {reg_list[i], 2'b00};
            pwdata <= 32'(values[i]);
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            while (!pready)
                @(posedge aclk);
            sb.set_dimension(reg_list[i], 32'(values[i]));
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        dim_settings++;
    endtask

    function automatic logic [31:0] random_element();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return 32'(int'($urandom_range(16)) - 8);
            default: return $urandom;
        endcase
    endfunction

    function automatic int random_dim();
        if ($urandom_range(7) == 0)
            return $urandom_range(31);
        return $urandom_range(1, 6);
    endfunction

    // mostly in-range loads and row computes, some malformed requests
    task automatic send_random_request();
        int         pick;
        logic [1:0] op;
        logic [3:0] row;
        logic [3:0] col;
        pick = $urandom_range(99);
        if (pick < 34) begin
            op = OP_WRITE_A;
            row = 4'($urandom_range(sb.rows_a - 1));
            col = 4'($urandom_range(sb.inner_dim - 1));
        end else if (pick < 68) begin
            op = OP_WRITE_B;
            row = 4'($urandom_range(sb.inner_dim - 1));
            col = 4'($urandom_range(sb.cols_b - 1));
        end else if (pick < 90) begin
            op = OP_COMPUTE;
            row = 4'($urandom_range(sb.rows_a - 1));
            col = 4'($urandom_range(15));
        end else begin
            op = 2'($urandom_range(3));
            row = 4'($urandom_range(15));
            col = 4'($urandom_range(15));
        end
        send_request(op, row, col, random_element());
    endtask

    initial begin
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cycle_count = 0;
        dim_settings = 0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        m_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // full-size corners at reset dimensions, including wrapping sums
        send_request(OP_WRITE_A, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_request(OP_WRITE_A, 4'd0, 4'd15, 32'h8000_0000);
        send_request(OP_WRITE_A, 4'd15, 4'd15, 32'hFFFF_FFFF);
        send_request(OP_WRITE_A, 4'd15, 4'd0, 32'd3);
        send_request(OP_WRITE_B, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_request(OP_WRITE_B, 4'd15, 4'd0, 32'h8000_0000);
        send_request(OP_WRITE_B, 4'd15, 4'd15, 32'hFFFF_FFFF);
        send_request(OP_WRITE_B, 4'd0, 4'd15, 32'd2);
        send_request(OP_COMPUTE, 4'd0, 4'd0, 32'd0);
        send_request(OP_COMPUTE, 4'd15, 4'd15, 32'hFFFF_FFFF);
        send_request(OP_UNUSED, 4'd15, 4'd15, 32'hFFFF_FFFF);
        send_request(OP_COMPUTE, 4'd7, 4'd3, 32'd0);
        drain_results();

        // zero acts as one, values above the cap saturate
        write_dimensions(0, 31, 2);
        send_request(OP_WRITE_A, 4'd1, 4'd0, 32'd9);
        send_request(OP_WRITE_A, 4'd0, 4'd15, 32'd5);
        send_request(OP_WRITE_B, 4'd15, 4'd1, 32'hFFFF_FFF9);
        send_request(OP_WRITE_B, 4'd0, 4'd2, 32'd1);
        send_request(OP_COMPUTE, 4'd0, 4'd0, 32'd0);
        send_request(OP_COMPUTE, 4'd1, 4'd0, 32'd0);
        send_request(OP_UNUSED, 4'd0, 4'd0, 32'd0);
        drain_results();

        // each index check on its own
        write_dimensions(3, 2, 4);
        send_request(OP_WRITE_A, 4'd2, 4'd2, 32'd1);
        send_request(OP_WRITE_B, 4'd2, 4'd0, 32'd1);
        send_request(OP_WRITE_A, 4'd2, 4'd1, 32'd12345);
        send_request(OP_WRITE_B, 4'd1, 4'd3, 32'hFFFF_FF9C);
        send_request(OP_COMPUTE, 4'd2, 4'd0, 32'd0);
        send_request(OP_COMPUTE, 4'd15, 4'd0, 32'd0);
        drain_results();

        // random phases, each with its own dimensions and idling
        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 54;
                end
                default: begin
                    send_idle_pct = 11;
                    recv_stall_pct = 11;
                end
            endcase
            if (phase == 0)
                write_dimensions(16, 16, 16);
            else if (phase == 1)
                write_dimensions(1, 1, 1);
            else
                write_dimensions(random_dim(), random_dim(), random_dim());
            for (int n = 0; n < 35; n++) begin
                if (phase == 2 && n == 17)
                    drain_results();
                send_random_request();
            end
            drain_results();
        end

        $display("run: %0d requests, %0d results, %0d rows computed, %0d error answers",
                 sb.request_count, sb.result_count, sb.rows_computed, sb.error_answers);
        $display("run: %0d dimension settings under four idling patterns",
                 dim_settings);
        if (sb.fail_count == 0 && sb.pending.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/mme_pkg.sv
rtl/core/matrix_multiply_engine_unit.sv
test/testbench.sv
